// ----- design/tbpc_pkg.sv -----
// Shared types and constants of the token budget phase controller.
// Holds the mode and request-function encodings, register indexes and field widths.
// No dependencies.
package tbpc_pkg;

    // Controller modes, as reported on mode_after
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_COUNT  = 3'd1,
        MODE_SPEND  = 3'd2,
        MODE_SFORCE = 3'd3,
        MODE_GRACE  = 3'd4,
        MODE_WAIT   = 3'd5,
        MODE_FORCE  = 3'd6,
        MODE_DONE   = 3'd7
    } mode_t;

    // Request functions
    typedef enum logic [1:0] {
        FUNC_TOKEN = 2'd0,
        FUNC_FORCE = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_START = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_BUDGET     = 3'd0;
    localparam logic [2:0] CFG_SOFT_LIMIT = 3'd1;
    localparam logic [2:0] CFG_GRACE      = 3'd2;
    localparam logic [2:0] CFG_FORCED_LEN = 3'd3;
    localparam logic [2:0] CFG_SOFT_LEN   = 3'd4;
    localparam logic [2:0] CFG_START_MODE = 3'd5;
    localparam logic [2:0] CFG_HAS_VOCAB  = 3'd6;

    // Field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int BUDGET_W   = 20;
    localparam int GRACE_W    = 16;
    localparam int LEN_W      = 6;
    localparam int IDX_W      = 6;
    localparam int TOKEN_W    = 18;
    localparam int EIDX_W     = 4;
    localparam int MATCH_W    = 5;

    // Reset values
    localparam logic [BUDGET_W-1:0]       BUDGET_RESET = 20'd1024;
    localparam logic signed [MATCH_W-1:0] MATCH_NONE   = 5'sb11111;
    localparam logic [GRACE_W-1:0]        GRACE_MAX    = 16'hFFFF;

endpackage

// ----- design/token_budget_phase_controller_unit.sv -----
// Top level of the token budget phase controller: input register, mode and counter
// update logic, result register and configuration registers.
// Depends on tbpc_pkg.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless out_stall holds the result. The mode and
// counters update in the cycle its result is registered, so the next sees them at once.
// Reset (rst_n low, asynchronous): mode idle, counters and positions zero, remaining count
// loaded from the budget reset value, last end match minus one, configuration registers
// at their reset values, both pipeline stages empty.
module token_budget_phase_controller_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_write,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0]   cfg_data,

    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [tbpc_pkg::TOKEN_W-1:0]      token_id,
    input  logic                              start_hit,
    input  logic                              end_hit,
    input  logic [tbpc_pkg::EIDX_W-1:0]       end_index,
    input  logic                              char_complete,
    input  logic                              has_newline,
    input  logic                              has_paragraph,

    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        mode_after,
    output logic                              force_valid,
    output logic                              force_from_soft,
    output logic [tbpc_pkg::IDX_W-1:0]        force_index,
    output logic signed [tbpc_pkg::MATCH_W-1:0] end_match_out,
    output logic                              start_advance,
    output logic                              end_advance,
    output logic                              start_clear,
    output logic                              end_clear,
    output logic                              accepted,
    output logic [tbpc_pkg::TOKEN_W-1:0]      token_echo
);

    localparam int POS_W   = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W   = (POS_W > tbpc_pkg::LEN_W) ? POS_W : tbpc_pkg::LEN_W;
    localparam int MW      = (COUNT_WIDTH > tbpc_pkg::BUDGET_W) ? COUNT_WIDTH
                                                                : tbpc_pkg::BUDGET_W;
    localparam int IDX_W   = tbpc_pkg::IDX_W;
    localparam int GRACE_W = tbpc_pkg::GRACE_W;
    localparam int LEN_W   = tbpc_pkg::LEN_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(TABLE_DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tbpc_pkg::BUDGET_W-1:0] budget_reg;
    logic [tbpc_pkg::BUDGET_W-1:0] soft_limit_reg;
    logic [GRACE_W-1:0]            grace_limit_reg;
    logic [LEN_W-1:0]              forced_len_reg;
    logic [LEN_W-1:0]              soft_len_reg;
    logic [2:0]                    start_mode_reg;
    logic                          has_vocab_reg;

    // Users must write only while idle (not enforced); no interlock with the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg      <= tbpc_pkg::BUDGET_RESET;
            soft_limit_reg  <= '0;
            grace_limit_reg <= '0;
            forced_len_reg  <= '0;
            soft_len_reg    <= '0;
            start_mode_reg  <= '0;
            has_vocab_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tbpc_pkg::CFG_BUDGET:     budget_reg      <= cfg_data;
                tbpc_pkg::CFG_SOFT_LIMIT: soft_limit_reg  <= cfg_data;
                tbpc_pkg::CFG_GRACE:      grace_limit_reg <= cfg_data[GRACE_W-1:0];
                tbpc_pkg::CFG_FORCED_LEN: forced_len_reg  <= cfg_data[LEN_W-1:0];
                tbpc_pkg::CFG_SOFT_LEN:   soft_len_reg    <= cfg_data[LEN_W-1:0];
                tbpc_pkg::CFG_START_MODE: start_mode_reg  <= cfg_data[2:0];
                tbpc_pkg::CFG_HAS_VOCAB:  has_vocab_reg   <= cfg_data[0];
                default:                  ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Budget seen at the counter width (truncate or zero-extend)
    logic [COUNT_WIDTH-1:0] budget_c;
    assign budget_c = COUNT_WIDTH'(budget_reg);

    // ------------------------------------------------------------------
    // Handshake: the result register advances when empty or not stalled;
    // the input register refills whenever its request moves on.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic process;

    assign advance  = !out_valid_reg || !out_stall;
    assign process  = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic [1:0]                   s1_func_reg;
    logic [tbpc_pkg::TOKEN_W-1:0] s1_token_reg;
    logic                         s1_shit_reg;
    logic                         s1_ehit_reg;
    logic [tbpc_pkg::EIDX_W-1:0]  s1_eidx_reg;
    logic                         s1_comp_reg;
    logic                         s1_nl_reg;
    logic                         s1_para_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg  <= func;
            s1_token_reg <= token_id;
            s1_shit_reg  <= start_hit;
            s1_ehit_reg  <= end_hit;
            s1_eidx_reg  <= end_index;
            s1_comp_reg  <= char_complete;
            s1_nl_reg    <= has_newline;
            s1_para_reg  <= has_paragraph;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    tbpc_pkg::mode_t                  mode_reg,   mode_next;
    logic [COUNT_WIDTH-1:0]           rem_reg,    rem_next;
    logic [POS_W-1:0]                 epos_reg,   epos_next;
    logic [POS_W-1:0]                 spos_reg,   spos_next;
    logic                             sdone_reg,  sdone_next;
    logic [GRACE_W-1:0]               grace_reg,  grace_next;
    logic signed [tbpc_pkg::MATCH_W-1:0] lem_reg, lem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tbpc_pkg::MODE_IDLE;
            rem_reg   <= COUNT_WIDTH'(tbpc_pkg::BUDGET_RESET);
            epos_reg  <= '0;
            spos_reg  <= '0;
            sdone_reg <= 1'b0;
            grace_reg <= '0;
            lem_reg   <= tbpc_pkg::MATCH_NONE;
        end
        else if (process)
        begin
            mode_reg  <= mode_next;
            rem_reg   <= rem_next;
            epos_reg  <= epos_next;
            spos_reg  <= spos_next;
            sdone_reg <= sdone_next;
            grace_reg <= grace_next;
            lem_reg   <= lem_next;
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic for one request
    // ------------------------------------------------------------------
    logic                   comp, nl, para;
    logic                   sadv, eadv, sclr, eclr, acc;
    logic [COUNT_WIDTH-1:0] rem_dec;
    logic [GRACE_W-1:0]     grace_inc;
    logic [POS_W-1:0]       epos_inc, spos_inc;
    logic                   soft_fire;
    logic signed [tbpc_pkg::MATCH_W-1:0] eidx_s;

    // Without vocabulary info every token counts as complete and on a line boundary.
    assign comp = has_vocab_reg ? s1_comp_reg : 1'b1;
    assign nl   = has_vocab_reg ? s1_nl_reg   : 1'b1;
    assign para = has_vocab_reg ? s1_para_reg : 1'b0;

    assign rem_dec   = rem_reg - COUNT_WIDTH'(1);
    assign grace_inc = (grace_reg < tbpc_pkg::GRACE_MAX) ? grace_reg + GRACE_W'(1) : grace_reg;
    assign epos_inc  = (epos_reg < POS_MAX) ? epos_reg + POS_W'(1) : POS_MAX;
    assign spos_inc  = (spos_reg < POS_MAX) ? spos_reg + POS_W'(1) : POS_MAX;
    assign eidx_s    = $signed({1'b0, s1_eidx_reg});

    // One-shot soft warning: consumed count reached the soft limit; skip it when the
    // remaining count sits above a lowered budget.
    assign soft_fire = (mode_reg == tbpc_pkg::MODE_COUNT) && !sdone_reg
                    && (soft_limit_reg != '0) && (rem_dec <= budget_c)
                    && (MW'(budget_c - rem_dec) >= MW'(soft_limit_reg));

    always_comb
    begin
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        epos_next  = epos_reg;
        spos_next  = spos_reg;
        sdone_next = sdone_reg;
        grace_next = grace_reg;
        lem_next   = lem_reg;
        sadv = 1'b0;
        eadv = 1'b0;
        sclr = 1'b0;
        eclr = 1'b0;
        acc  = 1'b0;

        case (tbpc_pkg::func_t'(s1_func_reg))
            tbpc_pkg::FUNC_TOKEN:
            begin
                case (mode_reg)
                    tbpc_pkg::MODE_IDLE,
                    tbpc_pkg::MODE_DONE:
                    begin
                        sadv = 1'b1;
                        if (s1_shit_reg)
                        begin
                            // arm a new block
                            mode_next  = tbpc_pkg::MODE_COUNT;
                            rem_next   = budget_c;
                            sdone_next = 1'b0;
                            grace_next = '0;
                            if (budget_c == '0)
                            begin
                                mode_next = tbpc_pkg::MODE_FORCE;
                                epos_next = '0;
                            end
                            if (mode_reg == tbpc_pkg::MODE_DONE)
                            begin
                                eclr     = 1'b1;
                                lem_next = tbpc_pkg::MATCH_NONE;
                            end
                        end
                    end
                    tbpc_pkg::MODE_COUNT,
                    tbpc_pkg::MODE_SPEND,
                    tbpc_pkg::MODE_GRACE,
                    tbpc_pkg::MODE_WAIT:
                    begin
                        eadv = 1'b1;
                        if (s1_ehit_reg)
                        begin
                            mode_next = tbpc_pkg::MODE_DONE;
                            lem_next  = eidx_s;
                        end
                        else if (mode_reg == tbpc_pkg::MODE_WAIT)
                        begin
                            if (comp)
                            begin
                                mode_next = tbpc_pkg::MODE_FORCE;
                                epos_next = '0;
                                eclr      = 1'b1;
                            end
                        end
                        else if (mode_reg == tbpc_pkg::MODE_GRACE)
                        begin
                            grace_next = grace_inc;
                            if (comp && para)
                            begin
                                mode_next = tbpc_pkg::MODE_FORCE;
                                epos_next = '0;
                                eclr      = 1'b1;
                            end
                            else if (grace_inc >= grace_limit_reg)
                            begin
                                eclr = 1'b1;
                                if (comp)
                                begin
                                    mode_next = tbpc_pkg::MODE_FORCE;
                                    epos_next = '0;
                                end
                                else
                                begin
                                    mode_next = tbpc_pkg::MODE_WAIT;
                                end
                            end
                        end
                        else if (rem_reg <= COUNT_WIDTH'(1))
                        begin
                            // budget spent: saturate and move to grace, forcing or waiting
                            rem_next = '0;
                            if (grace_limit_reg != '0)
                            begin
                                mode_next  = tbpc_pkg::MODE_GRACE;
                                grace_next = '0;
                            end
                            else
                            begin
                                eclr = 1'b1;
                                if (comp)
                                begin
                                    mode_next = tbpc_pkg::MODE_FORCE;
                                    epos_next = '0;
                                end
                                else
                                begin
                                    mode_next = tbpc_pkg::MODE_WAIT;
                                end
                            end
                        end
                        else
                        begin
                            rem_next = rem_dec;
                            if (soft_fire)
                            begin
                                sdone_next = 1'b1;
                                if (soft_len_reg != '0)
                                begin
                                    if (nl && comp)
                                    begin
                                        mode_next = tbpc_pkg::MODE_SFORCE;
                                        spos_next = '0;
                                    end
                                    else
                                    begin
                                        mode_next = tbpc_pkg::MODE_SPEND;
                                    end
                                end
                            end
                            else if (mode_reg == tbpc_pkg::MODE_SPEND && nl && comp)
                            begin
                                mode_next = tbpc_pkg::MODE_SFORCE;
                                spos_next = '0;
                            end
                        end
                    end
                    tbpc_pkg::MODE_SFORCE:
                    begin
                        spos_next = spos_inc;
                        if (CMP_W'(spos_inc) >= CMP_W'(soft_len_reg))
                        begin
                            mode_next = tbpc_pkg::MODE_COUNT;
                        end
                    end
                    tbpc_pkg::MODE_FORCE:
                    begin
                        eadv      = 1'b1;
                        epos_next = epos_inc;
                        if (CMP_W'(epos_inc) >= CMP_W'(forced_len_reg))
                        begin
                            mode_next = tbpc_pkg::MODE_DONE;
                            lem_next  = s1_ehit_reg ? eidx_s : tbpc_pkg::MATCH_NONE;
                        end
                    end
                    default: ;
                endcase
            end
            tbpc_pkg::FUNC_FORCE:
            begin
                if (mode_reg == tbpc_pkg::MODE_COUNT)
                begin
                    mode_next = tbpc_pkg::MODE_FORCE;
                    epos_next = '0;
                    eclr      = 1'b1;
                    acc       = 1'b1;
                end
            end
            tbpc_pkg::FUNC_RESET:
            begin
                // soft_position survives a reset request
                mode_next  = tbpc_pkg::MODE_IDLE;
                rem_next   = budget_c;
                epos_next  = '0;
                lem_next   = tbpc_pkg::MATCH_NONE;
                sdone_next = 1'b0;
                grace_next = '0;
                sclr       = 1'b1;
                eclr       = 1'b1;
            end
            tbpc_pkg::FUNC_START:
            begin
                mode_next = tbpc_pkg::mode_t'(start_mode_reg);
                if (start_mode_reg == tbpc_pkg::MODE_COUNT && budget_c == '0)
                begin
                    mode_next = tbpc_pkg::MODE_FORCE;
                end
                rem_next   = budget_c;
                epos_next  = '0;
                spos_next  = '0;
                lem_next   = tbpc_pkg::MATCH_NONE;
                sdone_next = 1'b0;
                grace_next = '0;
                sclr       = 1'b1;
                eclr       = 1'b1;
            end
            default: ;
        endcase
    end

    // Force lookup from the updated state: soft message first, then end sequence.
    logic             fv, fsoft;
    logic [IDX_W-1:0] fidx;

    always_comb
    begin
        fv    = 1'b0;
        fsoft = 1'b0;
        fidx  = '0;
        if (mode_next == tbpc_pkg::MODE_SFORCE
            && CMP_W'(spos_next) < CMP_W'(soft_len_reg))
        begin
            fv    = 1'b1;
            fsoft = 1'b1;
            fidx  = IDX_W'(spos_next);
        end
        else if (mode_next == tbpc_pkg::MODE_FORCE
                 && CMP_W'(epos_next) < CMP_W'(forced_len_reg))
        begin
            fv   = 1'b1;
            fidx = IDX_W'(epos_next);
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [2:0]                          mode_out_reg;
    logic                                fv_reg, fsoft_reg;
    logic [IDX_W-1:0]                    fidx_reg;
    logic signed [tbpc_pkg::MATCH_W-1:0] lem_out_reg;
    logic                                sadv_reg, eadv_reg, sclr_reg, eclr_reg, acc_reg;
    logic [tbpc_pkg::TOKEN_W-1:0]        token_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            mode_out_reg  <= mode_next;
            fv_reg        <= fv;
            fsoft_reg     <= fsoft;
            fidx_reg      <= fidx;
            lem_out_reg   <= lem_next;
            sadv_reg      <= sadv;
            eadv_reg      <= eadv;
            sclr_reg      <= sclr;
            eclr_reg      <= eclr;
            acc_reg       <= acc;
            token_out_reg <= s1_token_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign mode_after      = mode_out_reg;
    assign force_valid     = fv_reg;
    assign force_from_soft = fsoft_reg;
    assign force_index     = fidx_reg;
    assign end_match_out   = lem_out_reg;
    assign start_advance   = sadv_reg;
    assign end_advance     = eadv_reg;
    assign start_clear     = sclr_reg;
    assign end_clear       = eclr_reg;
    assign accepted        = acc_reg;
    assign token_echo      = token_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A forced token is only ever reported in one of the two forcing modes.
    a_force_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && force_valid |->
            mode_after == tbpc_pkg::MODE_SFORCE || mode_after == tbpc_pkg::MODE_FORCE)
        else $error("force reported outside a forcing mode");

    // A manual force that took effect lands in forcing and clears the end matcher.
    a_accept_force: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> mode_after == tbpc_pkg::MODE_FORCE && end_clear)
        else $error("accepted manual force without entering forcing");

    // Clearing the start matcher always comes with clearing the end matcher.
    a_clear_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_clear |-> end_clear && !start_advance && !end_advance)
        else $error("start matcher cleared alone or while advancing");

    // The state only moves when a request is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(mode_reg) && $stable(rem_reg) && $stable(lem_reg))
        else $error("controller state changed without a request");

endmodule
